// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/rmr_pkg.sv
// Types and constants of the report message reassembler.
`default_nettype none
package rmr_pkg;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_TOO_BIG  = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   localparam logic [7:0] START_MARK  = 8'h3F;
   localparam logic [7:0] HEAD_MARK   = 8'h23;
   localparam logic [5:0] REPORT_LAST = 6'd63;

   localparam logic [5:0] IDX_START = 6'd0;
   localparam logic [5:0] IDX_HEAD1 = 6'd1;
   localparam logic [5:0] IDX_HEAD2 = 6'd2;
   localparam logic [5:0] IDX_ID_HI = 6'd3;
   localparam logic [5:0] IDX_ID_LO = 6'd4;
   localparam logic [5:0] IDX_LEN3  = 6'd5;
   localparam logic [5:0] IDX_LEN2  = 6'd6;
   localparam logic [5:0] IDX_LEN1  = 6'd7;
   localparam logic [5:0] IDX_LEN0  = 6'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [9:0]  offset;
      logic [15:0] message_id;
      logic [31:0] message_size;
      logic        last;
   } rsp_item_type;
endpackage
`default_nettype wire

// File: hw/rtl/report_message_reassembler.sv
// Report message reassembler: rebuilds framed messages from 64-byte report bytes.
//
// Input channel req_*: one report byte per transfer with its index in the report.
// Result channel rsp_*: payload bytes with their offset, completion and too-big
// results, each with the held message id and declared length; tlast marks the
// final result caused by one input byte.
// An input byte is decoded in the cycle it is accepted and its zero, one or two
// results are written to a four-entry result queue; rsp_* presents the entry at
// the head of that queue.
// Throughput is one byte per cycle while the receiver accepts results and each byte
// yields at most one result; a report-end byte with payload and completion yields
// two results and the queue drains them at one per cycle while rsp_tready is high.
// req_tready is high while the queue has room for two results, so a stalled
// receiver fills the queue and then holds off the sender; nothing is dropped.
// Reset empties the queue, returns to idle, sets the held id to all ones and
// clears held length and position.
`default_nettype none
module report_message_reassembler #(
   parameter int MSG_CAPACITY = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] report_byte, [13:8] byte_index, [15:14] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] payload_byte, [17:8] offset, [33:18] message_id,
                                    // [65:34] message_size, [71:66] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import rmr_pkg::*;
   `include "assert_macros.svh"

   localparam int          PosW = $clog2(MSG_CAPACITY + 1);
   localparam logic [31:0] Cap  = 32'(MSG_CAPACITY);

   logic            reading_ff, reading_in;
   logic            discard_ff, discard_in;
   logic [15:0]     held_id_ff, held_id_in;
   logic [31:0]     held_size_ff, held_size_in;
   logic [PosW-1:0] position_ff, position_in;

   rsp_item_type    queue_ff [4];
   logic [1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [2:0]      count_ff;

   rsp_item_type    res_a, res_b;
   logic [1:0]      num_res;
   logic            req_xfer, rsp_xfer, complete;
   logic [7:0]      b;
   logic [5:0]      idx;
   logic [31:0]     pos_w;
   rsp_item_type    head;

   assign b        = req_tdata[7:0];
   assign idx      = req_tdata[13:8];
   assign pos_w    = 32'(position_ff);
   assign req_tready = (count_ff <= 3'd2);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      reading_in   = reading_ff;
      discard_in   = discard_ff;
      held_id_in   = held_id_ff;
      held_size_in = held_size_ff;
      position_in  = position_ff;
      num_res      = 2'd0;
      complete     = 1'b0;
      res_a        = '0;
      res_b        = '0;
      if (!reading_ff) begin
         if (idx == IDX_START) begin
            discard_in = (b != START_MARK);
         end else if (!discard_ff) begin
            case (idx)
               IDX_HEAD1, IDX_HEAD2: begin
                  if (b != HEAD_MARK) discard_in = 1'b1;
               end
               IDX_ID_HI: held_id_in[15:8]   = b;
               IDX_ID_LO: held_id_in[7:0]    = b;
               IDX_LEN3:  held_size_in[31:24] = b;
               IDX_LEN2:  held_size_in[23:16] = b;
               IDX_LEN1:  held_size_in[15:8]  = b;
               IDX_LEN0: begin
                  held_size_in[7:0] = b;
                  if (held_size_in > Cap) begin
                     res_a.kind         = KIND_TOO_BIG;
                     res_a.message_id   = held_id_ff;
                     res_a.message_size = held_size_in;
                     res_a.last         = 1'b1;
                     num_res            = 2'd1;
                     discard_in         = 1'b1;
                  end else begin
                     reading_in  = 1'b1;
                     position_in = '0;
                  end
               end
               default: ;
            endcase
         end
      end else if (idx == IDX_START) begin
         if (b != START_MARK) begin
            reading_in = 1'b0;
            discard_in = 1'b1;
         end else begin
            discard_in = 1'b0;
         end
      end else begin
         if (position_ff != PosW'(MSG_CAPACITY)) position_in = position_ff + 1'b1;
         complete = (idx == REPORT_LAST) && (32'(position_in) >= held_size_ff);
         if (pos_w < held_size_ff && pos_w < Cap) begin
            res_a.kind         = KIND_PAYLOAD;
            res_a.payload_byte = b;
            res_a.offset       = 10'(position_ff);
            res_a.message_id   = held_id_ff;
            res_a.message_size = held_size_ff;
            res_a.last         = (idx != REPORT_LAST) || !complete;
            num_res            = 2'd1;
         end
         if (complete) begin
            res_b.kind         = KIND_COMPLETE;
            res_b.message_id   = held_id_ff;
            res_b.message_size = held_size_ff;
            res_b.last         = 1'b1;
            if (num_res == 2'd0) begin
               res_a   = res_b;
               num_res = 2'd1;
            end else begin
               num_res = 2'd2;
            end
            position_in = '0;
            reading_in  = 1'b0;
            discard_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff   <= 1'b0;
         discard_ff   <= 1'b0;
         held_id_ff   <= 16'hFFFF;
         held_size_ff <= '0;
         position_ff  <= '0;
      end else if (req_xfer) begin
         reading_ff   <= reading_in;
         discard_ff   <= discard_in;
         held_id_ff   <= held_id_in;
         held_size_ff <= held_size_in;
         position_ff  <= position_in;
      end
   end

   logic [1:0] push_num;
   assign push_num = req_xfer ? num_res : 2'd0;

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) queue_ff[wr_ptr_ff] <= res_a;
      if (push_num == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_num;
         if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push_num) - 3'(rsp_xfer);
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {6'd0, head.message_size, head.message_id, head.offset,
                        head.payload_byte};

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= 3'd4, "result queue overflow")
   `ASSERT_CLK(a_kind_valid, clock, reset, rsp_tvalid |-> (rsp_tuser != KIND_UNUSED),
      "reserved result kind presented")
   `ASSERT_CLK(a_pos_bound, clock, reset, position_ff <= PosW'(MSG_CAPACITY),
      "position past capacity")
   `ASSERT_CLK(a_idle_no_pos, clock, reset,
      (req_xfer && complete) |=> (!reading_ff && position_ff == '0),
      "completion did not return to idle")
endmodule
`default_nettype wire

// File: tb/tb_report_message_reassembler.sv
// Testbench for report_message_reassembler: predicts results per transfer and checks the stream.
`timescale 1ns / 1ps

module tb_report_message_reassembler;
   import rmr_pkg::*;

   localparam int MSG_CAPACITY  = 1024;
   localparam int FIRST_PAYLOAD = 55;
   localparam int CONT_PAYLOAD  = 63;

   typedef enum {FLAW_NONE, FLAW_BAD_START, FLAW_BAD_HEAD, FLAW_BAD_CONT, FLAW_CUT} flaw_type;

   class message_scoreboard;
      bit           reading     = 1'b0;
      bit           skip_report = 1'b0;
      logic [15:0]  msg_id      = 16'hFFFF;
      logic [31:0]  msg_len     = 32'd0;
      int unsigned  pos         = 0;
      rsp_item_type pending_results[$];
      int           errors      = 0;

      function void add_result(logic [1:0] kind, logic [7:0] b, logic [9:0] off, logic last);
         rsp_item_type item;
         item.kind         = kind;
         item.payload_byte = b;
         item.offset       = off;
         item.message_id   = msg_id;
         item.message_size = msg_len;
         item.last         = last;
         pending_results.push_back(item);
      endfunction

      function void decode_byte(logic [7:0] b, logic [5:0] idx);
         bit         emit;
         logic [9:0] off;
         if (!reading) begin
            if (idx == IDX_START) begin
               skip_report = (b != START_MARK);
            end else if (!skip_report) begin
               case (idx)
                  IDX_HEAD1, IDX_HEAD2: if (b != HEAD_MARK) skip_report = 1'b1;
                  IDX_ID_HI: msg_id[15:8] = b;
                  IDX_ID_LO: msg_id[7:0] = b;
                  IDX_LEN3: msg_len[31:24] = b;
                  IDX_LEN2: msg_len[23:16] = b;
                  IDX_LEN1: msg_len[15:8] = b;
                  IDX_LEN0: begin
                     msg_len[7:0] = b;
                     if (msg_len > MSG_CAPACITY) begin
                        add_result(KIND_TOO_BIG, 8'h00, 10'd0, 1'b1);
                        skip_report = 1'b1;
                     end else begin
                        reading = 1'b1;
                        pos = 0;
                     end
                  end
                  default: ;
               endcase
            end
            return;
         end
         if (idx == IDX_START) begin
            reading = (b == START_MARK);
            skip_report = (b != START_MARK);
            return;
         end
         emit = (pos < msg_len) && (pos < MSG_CAPACITY);
         off = pos[9:0];
         if (pos < MSG_CAPACITY) pos++;
         if (idx == REPORT_LAST && pos >= msg_len) begin
            if (emit) add_result(KIND_PAYLOAD, b, off, 1'b0);
            add_result(KIND_COMPLETE, 8'h00, 10'd0, 1'b1);
            pos = 0;
            reading = 1'b0;
            skip_report = 1'b0;
         end else if (emit) begin
            add_result(KIND_PAYLOAD, b, off, 1'b1);
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            $error("kind: expected no transfer, actual %0d", got.kind);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("offset", want.offset, got.offset);
         compare_field("message_id", want.message_id, got.message_id);
         compare_field("message_size", want.message_size, got.message_size);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;     // [7:0] report_byte, [13:8] byte_index, [15:14] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // [7:0] payload_byte, [17:8] offset, [33:18] message_id,
                                     // [65:34] message_size, [71:66] zero
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        rsp_tlast;

   message_scoreboard board;
   rsp_item_type      seen;
   int                idle_pct   = 0;
   int                stall_left = 0;
   int                sent_count = 0;

   report_message_reassembler #(.MSG_CAPACITY(MSG_CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // outputs are stable mid-cycle; a transfer seen here completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && req_tvalid && req_tready) board.decode_byte(req_tdata[7:0], req_tdata[13:8]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[17:8], rsp_tdata[33:18],
                 rsp_tdata[65:34], rsp_tlast};
         board.check_result(seen);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic [5:0] idx);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, idx, b};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic send_message(input logic [15:0] id, input logic [31:0] len,
                               input flaw_type flaw);
      logic [7:0] head [0:8];
      logic [7:0] b;
      logic [7:0] bad_start;
      int         reports;
      int         stop_report;
      int         stop_index;
      head = '{START_MARK, HEAD_MARK, HEAD_MARK, id[15:8], id[7:0],
               len[31:24], len[23:16], len[15:8], len[7:0]};
      bad_start = START_MARK ^ 8'($urandom_range(1, 255));
      if (len > MSG_CAPACITY)
         reports = 1;
      else
         reports = 1 + ((len > FIRST_PAYLOAD ? len - FIRST_PAYLOAD : 0) + CONT_PAYLOAD - 1)
                   / CONT_PAYLOAD;
      stop_report = reports - 1;
      stop_index  = REPORT_LAST;
      if (len > MSG_CAPACITY || flaw == FLAW_BAD_START || flaw == FLAW_BAD_HEAD) begin
         stop_report = 0;
         stop_index  = $urandom_range(8, 12);
      end
      if (flaw == FLAW_BAD_START) head[0] = bad_start;
      if (flaw == FLAW_BAD_HEAD)
         head[$urandom_range(1, 2)] = HEAD_MARK ^ 8'(1 << $urandom_range(0, 7));
      if (flaw == FLAW_BAD_CONT && reports > 1) begin
         stop_report = $urandom_range(1, reports - 1);
         stop_index  = $urandom_range(0, 5);
      end
      if (flaw == FLAW_CUT) begin
         stop_report = $urandom_range(0, reports - 1);
         stop_index  = $urandom_range(1, 62);
      end
      for (int n = 0; n <= stop_report * 64 + stop_index; n++) begin
         if (n < 9)
            b = head[n];
         else if (n % 64 == 0)
            b = (flaw == FLAW_BAD_CONT && n / 64 == stop_report) ? bad_start : START_MARK;
         else
            b = 8'($urandom);
         send_byte(b, 6'(n % 64));
      end
   endtask

   initial begin
      logic [7:0]  hdr [0:8];
      int          target;
      int          pick;
      logic [31:0] len;
      flaw_type    flaw;
      bit          big_done;
      board = new();
      big_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 15;

      // bad start, then a header mark that must be ignored
      send_byte(8'h00, IDX_START);
      send_byte(HEAD_MARK, IDX_HEAD1);
      // bad header mark
      send_byte(START_MARK, IDX_START);
      send_byte(8'h22, IDX_HEAD1);
      send_byte(HEAD_MARK, IDX_HEAD2);
      // too big with the id never written, length bytes only
      send_byte(START_MARK, IDX_START);
      send_byte(HEAD_MARK, IDX_HEAD1);
      send_byte(HEAD_MARK, IDX_HEAD2);
      send_byte(8'hFF, IDX_LEN3);
      send_byte(8'hFF, IDX_LEN2);
      send_byte(8'hFF, IDX_LEN1);
      send_byte(8'hFF, IDX_LEN0);
      // one-byte message whose only payload lands on the report end
      hdr = '{START_MARK, HEAD_MARK, HEAD_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
      foreach (hdr[i]) send_byte(hdr[i], 6'(i));
      send_byte(8'hFF, REPORT_LAST);

      target = sent_count + 450;
      while (sent_count < target || !big_done) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         if (!big_done && sent_count > target - 250) begin
            send_message(16'($urandom), MSG_CAPACITY, FLAW_NONE);
            big_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
               send_byte(($urandom_range(0, 3) == 0) ? START_MARK : 8'($urandom),
                         6'($urandom_range(0, 63)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       len = MSG_CAPACITY + 1;
            else if (pick < 10) len = $urandom_range(MSG_CAPACITY + 2, 32'hFFFF_FFFF);
            else if (pick < 15) len = 0;
            else if (pick < 60) len = $urandom_range(1, FIRST_PAYLOAD);
            else if (pick < 90) len = $urandom_range(FIRST_PAYLOAD + 1, 181);
            else                len = $urandom_range(182, 400);
            pick = $urandom_range(0, 99);
            if (pick < 6)       flaw = FLAW_BAD_START;
            else if (pick < 12) flaw = FLAW_BAD_HEAD;
            else if (pick < 22) flaw = FLAW_BAD_CONT;
            else if (pick < 30) flaw = FLAW_CUT;
            else                flaw = FLAW_NONE;
            send_message(16'($urandom), len, flaw);
         end
      end

      idle_pct = 0;
      repeat (3) send_message(16'($urandom), $urandom_range(0, 120), FLAW_NONE);
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending_results.size() == 0)
         $display("tb_report_message_reassembler passed");
      else
         $display("tb_report_message_reassembler failed");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("tb_report_message_reassembler failed");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rmr_pkg.sv
hw/rtl/report_message_reassembler.sv
tb/tb_report_message_reassembler.sv
